### hdl/elias_fano_stream_encoder_defines.svh
// Assertion macros shared by the encoder modules.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ELIAS_FANO_STREAM_ENCODER_DEFINES_SVH
`define ELIAS_FANO_STREAM_ENCODER_DEFINES_SVH

// Same-cycle implication.
`define EFSE_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("efse assertion failed: implication");

// Next-cycle implication.
`define EFSE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("efse assertion failed: next-cycle implication");

`endif

### hdl/efse_pkg.sv
package efse_pkg;

    localparam int VALUE_W = 64;
    localparam int LW_W    = 6;
    localparam int POS_W   = 61;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [1:0] KIND_LOW  = 2'd0;
    localparam logic [1:0] KIND_HIGH = 2'd1;
    localparam logic [1:0] KIND_RUN  = 2'd2;

    // Everything one input item asks the back end to send, in output order.
    typedef struct packed {
        logic               err;
        logic [63:0]        low_data;
        logic [3:0]         low_count;
        logic               hb_en;
        logic [7:0]         hb;
        logic               run_en;
        logic [POS_W-1:0]   run;
        logic               flow_en;
        logic [6:0]         flow;
        logic               last;
        logic [7:0]         fhigh;
        logic               trail_en;
    } job_t;

endpackage

### hdl/efse_front.sv
`include "elias_fano_stream_encoder_defines.svh"

module efse_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [efse_pkg::LW_W-1:0]    low_width,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [efse_pkg::VALUE_W-1:0] value,
    input  logic                         last_value,
    output logic                         push,
    output efse_pkg::job_t               job,
    input  logic                         q_full
);

    logic adv;

    // Stage 1 state and registers
    logic [63:0] items_seen_reg, items_seen_next;
    logic [63:0] prev_reg, prev_next;
    logic        s1_valid_reg;
    logic [63:0] s1_low_reg, s1_h_reg, s1_i_reg;
    logic        s1_err_reg, s1_last_reg;

    // Stage 2 state and registers
    logic [6:0]  pend_bits_reg, pend_bits_next;
    logic [2:0]  pend_cnt_reg, pend_cnt_next;
    logic        s2_valid_reg;
    logic [63:0] s2_low_reg;
    logic [3:0]  s2_nbytes_reg;
    logic [efse_pkg::POS_W-1:0] s2_b_reg;
    logic [2:0]  s2_bit_reg;
    logic        s2_err_reg, s2_last_reg, s2_flow_en_reg;
    logic [6:0]  s2_flow_reg;

    // Stage 3 state
    logic [efse_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]  part_reg, part_next;

    logic [63:0] mask;
    logic        accept;
    logic        err_in;

    logic [70:0] packed_w;
    logic [70:0] rest;
    logic [6:0]  total;
    logic [3:0]  lowsum;
    logic [62:0] hsum;
    logic [efse_pkg::POS_W-1:0] b_sat;

    logic [efse_pkg::POS_W:0] e_sum, d_sum;
    logic        gt, eq;
    logic [7:0]  bit_oh, part_upd;
    logic        hb_en, run_en, nonempty;
    logic [efse_pkg::POS_W-1:0] run_val;

    // The queue takes one job per cycle, so the pipe only halts when it is full.
    assign adv      = !(s2_valid_reg && q_full);
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    // Stage 1: mask and shift, order check.
    assign mask   = ~({64{1'b1}} << low_width);
    assign err_in = (items_seen_reg != 64'd0) && (value < prev_reg);

    always_comb
    begin
        items_seen_next = items_seen_reg;
        prev_next       = prev_reg;
        if (accept)
        begin
            items_seen_next = last_value ? 64'd0 : items_seen_reg + 64'd1;
            prev_next       = last_value ? 64'd0 : value;
        end
    end

    // Stage 2: low-part packing and the high byte index.
    assign packed_w = ({7'd0, s1_low_reg} << pend_cnt_reg) | {64'd0, pend_bits_reg};
    assign total    = {4'd0, pend_cnt_reg} + {1'b0, low_width};
    assign rest     = packed_w >> {total[6:3], 3'b000};
    assign lowsum   = {1'b0, s1_h_reg[2:0]} + {1'b0, s1_i_reg[2:0]};
    assign hsum     = {2'd0, s1_h_reg[63:3]} + {2'd0, s1_i_reg[63:3]} + {62'd0, lowsum[3]};
    assign b_sat    = (hsum[62:61] != 2'd0) ? {efse_pkg::POS_W{1'b1}} : hsum[60:0];

    always_comb
    begin
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (adv && s1_valid_reg)
        begin
            pend_bits_next = s1_last_reg ? 7'd0 : rest[6:0];
            pend_cnt_next  = s1_last_reg ? 3'd0 : total[2:0];
        end
    end

    // Stage 3: place the unary bit against the current high byte.
    // e_sum is b - pos - 1 with its carry telling b > pos.
    assign e_sum    = {1'b0, s2_b_reg} + {1'b0, ~pos_reg};
    assign d_sum    = {1'b0, s2_b_reg} - {1'b0, pos_reg};
    assign gt       = e_sum[efse_pkg::POS_W];
    assign eq       = (s2_b_reg == pos_reg);
    assign bit_oh   = 8'd1 << s2_bit_reg;
    assign hb_en    = gt && (part_reg != 8'd0);
    assign run_val  = (part_reg != 8'd0) ? e_sum[efse_pkg::POS_W-1:0]
                                         : d_sum[efse_pkg::POS_W-1:0];
    assign run_en   = gt && ((part_reg == 8'd0) || (e_sum[efse_pkg::POS_W-1:0] != '0));
    assign part_upd = gt ? bit_oh : (eq ? (part_reg | bit_oh) : part_reg);
    assign nonempty = (s2_nbytes_reg != 4'd0) || hb_en || run_en || s2_last_reg;

    always_comb
    begin
        pos_next  = pos_reg;
        part_next = part_reg;
        if (adv && s2_valid_reg)
        begin
            pos_next  = s2_last_reg ? '0 : (gt ? s2_b_reg : pos_reg);
            part_next = s2_last_reg ? 8'd0 : part_upd;
        end
    end

    always_comb
    begin
        job.err       = s2_err_reg;
        job.low_data  = s2_low_reg;
        job.low_count = s2_nbytes_reg;
        job.hb_en     = hb_en;
        job.hb        = part_reg;
        job.run_en    = run_en;
        job.run       = run_val;
        job.flow_en   = s2_flow_en_reg;
        job.flow      = s2_flow_reg;
        job.last      = s2_last_reg;
        job.fhigh     = part_upd;
        job.trail_en  = s2_last_reg && (s2_bit_reg == 3'd7);
    end

    assign push = s2_valid_reg && adv && nonempty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_seen_reg <= '0;
            prev_reg       <= '0;
            pend_bits_reg  <= '0;
            pend_cnt_reg   <= '0;
            pos_reg        <= '0;
            part_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
        end
        else
        begin
            items_seen_reg <= items_seen_next;
            prev_reg       <= prev_next;
            pend_bits_reg  <= pend_bits_next;
            pend_cnt_reg   <= pend_cnt_next;
            pos_reg        <= pos_next;
            part_reg       <= part_next;
            if (adv)
            begin
                s1_valid_reg <= in_valid;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_low_reg     <= value & mask;
            s1_h_reg       <= value >> low_width;
            s1_i_reg       <= items_seen_reg;
            s1_err_reg     <= err_in;
            s1_last_reg    <= last_value;
            s2_low_reg     <= packed_w[63:0];
            s2_nbytes_reg  <= total[6:3];
            s2_b_reg       <= b_sat;
            s2_bit_reg     <= lowsum[2:0];
            s2_err_reg     <= s1_err_reg;
            s2_last_reg    <= s1_last_reg;
            s2_flow_en_reg <= s1_last_reg && (total[2:0] != 3'd0);
            s2_flow_reg    <= rest[6:0];
        end
    end

    `EFSE_ASSERT_IMP(a_pend_clean, 1'b1, (pend_bits_reg >> pend_cnt_reg) == 7'd0)
    `EFSE_ASSERT_IMP(a_pos_has_byte, pos_reg != '0, part_reg != 8'd0)
    `EFSE_ASSERT_NEXT(a_set_end, accept && last_value, items_seen_reg == 64'd0 && prev_reg == 64'd0)

endmodule

### hdl/efse_fifo.sv
module efse_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  efse_pkg::job_t wr_job,
    output logic           full,
    input  logic           pop,
    output efse_pkg::job_t rd_job,
    output logic           empty
);

    efse_pkg::job_t mem [efse_pkg::Q_DEPTH];

    logic [efse_pkg::Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [efse_pkg::Q_CNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == efse_pkg::Q_CNT_W'(efse_pkg::Q_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

### hdl/efse_back.sv
`include "elias_fano_stream_encoder_defines.svh"

module efse_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  efse_pkg::job_t              head,
    input  logic                        q_empty,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  kind,
    output logic [7:0]                  data_byte,
    output logic [efse_pkg::POS_W-1:0]  run_length,
    output logic                        order_error,
    output logic                        last_result
);

    // Bit positions of the result groups, in output order.
    localparam int PH_LOW   = 0;
    localparam int PH_HBYTE = 1;
    localparam int PH_RUN   = 2;
    localparam int PH_FLOW  = 3;
    localparam int PH_FHIGH = 4;
    localparam int PH_TRAIL = 5;

    logic [5:0] rem_reg, rem_next;
    logic [2:0] idx_reg, idx_next;
    logic [5:0] act, eff, sel, rem_after;
    logic       fire, low_done;

    logic                       out_valid_reg;
    logic [1:0]                 kind_reg, kind_next;
    logic [7:0]                 byte_reg, byte_next;
    logic [efse_pkg::POS_W-1:0] run_reg, run_next;
    logic                       err_reg, last_reg;

    assign act = {head.trail_en, head.last, head.flow_en, head.run_en, head.hb_en,
                  head.low_count != 4'd0};
    // A zero mask means the head job has not been started yet.
    assign eff      = (rem_reg == 6'd0) ? act : rem_reg;
    assign sel      = eff & (~eff + 6'd1);
    assign fire     = !q_empty && (!out_valid_reg || !out_stall);
    assign low_done = ({1'b0, idx_reg} + 4'd1) == head.low_count;
    assign rem_after = (sel[PH_LOW] && !low_done) ? eff : (eff & ~sel);
    assign pop      = fire && (rem_after == 6'd0);

    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (fire)
        begin
            rem_next = rem_after;
            idx_next = (sel[PH_LOW] && !low_done) ? idx_reg + 3'd1 : 3'd0;
        end
    end

    always_comb
    begin
        kind_next = efse_pkg::KIND_HIGH;
        byte_next = 8'd0;
        run_next  = '0;
        if (sel[PH_LOW])
        begin
            kind_next = efse_pkg::KIND_LOW;
            byte_next = head.low_data[{idx_reg, 3'b000} +: 8];
        end
        else if (sel[PH_HBYTE])
        begin
            byte_next = head.hb;
        end
        else if (sel[PH_RUN])
        begin
            kind_next = efse_pkg::KIND_RUN;
            run_next  = head.run;
        end
        else if (sel[PH_FLOW])
        begin
            kind_next = efse_pkg::KIND_LOW;
            byte_next = {1'b0, head.flow};
        end
        else if (sel[PH_FHIGH])
        begin
            byte_next = head.fhigh;
        end
        else if (sel[PH_TRAIL])
        begin
            byte_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            run_reg  <= run_next;
            err_reg  <= head.err;
            last_reg <= (rem_after == 6'd0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign data_byte   = byte_reg;
    assign run_length  = run_reg;
    assign order_error = err_reg;
    assign last_result = last_reg;

    `EFSE_ASSERT_IMP(a_busy_has_job, rem_reg != 6'd0, !q_empty)
    `EFSE_ASSERT_IMP(a_rem_subset, rem_reg != 6'd0, (rem_reg & ~act) == 6'd0)
    `EFSE_ASSERT_IMP(a_low_idx, fire && sel[PH_LOW], {1'b0, idx_reg} < head.low_count)

endmodule

### hdl/elias_fano_stream_encoder.sv
// Elias-Fano encoder for a non-decreasing stream of 64-bit values. Each value
// word yields its low-part bytes (low_width bits per value, packed LSB first),
// then any finished high-part byte and one run-length word for a stretch of
// zero high bytes; the value marked last_value also flushes the partial low
// byte, the partial high byte and, when needed, a trailing zero byte, and then
// clears the stream state. Input words enter a three-stage front end at one per
// clock when not stalled and are queued four deep as result jobs; the back end
// sends one result word per clock, unless out_stall holds it, through an output
// register. An item makes from 0 up to 13 results (about low_width/8 low bytes
// plus up to two high results, three more on the last value), and that single
// result port sets the sustained rate. Results pass the stage 1 and 2 registers,
// the queue and the output register. low_width is written through the cfg port,
// which is always ready, and must only change while the encoder is idle.
module elias_fano_stream_encoder
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [efse_pkg::LW_W-1:0]    low_width,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [efse_pkg::VALUE_W-1:0] value,
    input  logic                         last_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   kind,
    output logic [7:0]                   data_byte,
    output logic [efse_pkg::POS_W-1:0]   run_length,
    output logic                         order_error,
    output logic                         last_result
);

    logic [efse_pkg::LW_W-1:0] low_width_reg;
    logic                      push, pop, q_full, q_empty;
    efse_pkg::job_t            wr_job, rd_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_width_reg <= '0;
        end
        else if (cfg_valid)
        begin
            low_width_reg <= low_width;
        end
    end

    efse_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .low_width  (low_width_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .last_value (last_value),
        .push       (push),
        .job        (wr_job),
        .q_full     (q_full)
    );

    efse_fifo u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .full   (q_full),
        .pop    (pop),
        .rd_job (rd_job),
        .empty  (q_empty)
    );

    efse_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (rd_job),
        .q_empty     (q_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .data_byte   (data_byte),
        .run_length  (run_length),
        .order_error (order_error),
        .last_result (last_result)
    );

endmodule
